FILE: rtl/core/tsm_pkg.sv
// ----------------------------------------------------------------------------
// Two-way sorted merge package
// Shared types, sizes and request codes for the sorted merge core.
// ----------------------------------------------------------------------------
package tsm_pkg;

    localparam int SEQ_DEPTH = 32;
    localparam int ADDR_W    = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;
    localparam int CNT_W     = $clog2(SEQ_DEPTH + 1);
    localparam int DATA_W    = 32;

    localparam logic [1:0] REQ_APPEND_A = 2'd0;
    localparam logic [1:0] REQ_APPEND_B = 2'd1;
    localparam logic [1:0] REQ_START    = 2'd2;

    typedef struct packed {
        logic [1:0]               req_type;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] merged_value;
        logic                     from_b;
        logic                     last;
        logic                     empty_res;
        logic                     overflowed;
    } rsp_t;

    typedef enum logic [0:0] {
        ST_IDLE  = 1'b0,
        ST_MERGE = 1'b1
    } state_t;

    typedef struct packed {
        logic append_a;
        logic append_b;
        logic start;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic pick_last;
    } sts_t;

endpackage

FILE: rtl/core/tsm_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted merge controller
// Accepts appends and start requests while idle, then, while the output
// is free, paces one merge beat per cycle until the last value is emitted.
// ----------------------------------------------------------------------------
module tsm_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic [1:0]     req_type,
    output logic           req_stall,
    input  tsm_pkg::sts_t  sts,
    output tsm_pkg::cmd_t  cmd
);

    tsm_pkg::state_t state_reg;
    tsm_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tsm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req_stall  = 1'b1;
        cmd        = '0;
        case (state_reg)
            tsm_pkg::ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    case (req_type)
                        tsm_pkg::REQ_APPEND_A: cmd.append_a = 1'b1;
                        tsm_pkg::REQ_APPEND_B: cmd.append_b = 1'b1;
                        tsm_pkg::REQ_START:
                        begin
                            cmd.start  = 1'b1;
                            state_next = tsm_pkg::ST_MERGE;
                        end
                        default: ;
                    endcase
                end
            end
            tsm_pkg::ST_MERGE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.pick_last)
                    begin
                        state_next = tsm_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = tsm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/tsm_dpath.sv
// ----------------------------------------------------------------------------
// Sorted merge datapath
// Holds both value stores, their fill counts, the read indexes, the
// head compare and the output register.
// ----------------------------------------------------------------------------
module tsm_dpath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic signed [tsm_pkg::DATA_W-1:0] req_value,
    input  tsm_pkg::cmd_t                     cmd,
    output tsm_pkg::sts_t                     sts,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output tsm_pkg::rsp_t                     rsp
);

    logic signed [tsm_pkg::DATA_W-1:0] mem_a [tsm_pkg::SEQ_DEPTH];
    logic signed [tsm_pkg::DATA_W-1:0] mem_b [tsm_pkg::SEQ_DEPTH];

    logic signed [tsm_pkg::DATA_W-1:0] head_a_reg;
    logic signed [tsm_pkg::DATA_W-1:0] head_b_reg;

    logic [tsm_pkg::CNT_W-1:0] cnt_a_reg;
    logic [tsm_pkg::CNT_W-1:0] cnt_a_next;
    logic [tsm_pkg::CNT_W-1:0] cnt_b_reg;
    logic [tsm_pkg::CNT_W-1:0] cnt_b_next;
    logic [tsm_pkg::CNT_W-1:0] idx_a_reg;
    logic [tsm_pkg::CNT_W-1:0] idx_a_next;
    logic [tsm_pkg::CNT_W-1:0] idx_b_reg;
    logic [tsm_pkg::CNT_W-1:0] idx_b_next;
    logic                      ovf_reg;
    logic                      ovf_next;

    logic          rsp_valid_reg;
    logic          rsp_valid_next;
    tsm_pkg::rsp_t rsp_reg;
    tsm_pkg::rsp_t rsp_next;

    logic                    a_avail;
    logic                    b_avail;
    logic                    take_a;
    logic                    full_a;
    logic                    full_b;
    logic                    both_empty;
    logic [tsm_pkg::CNT_W:0] total;
    logic [tsm_pkg::CNT_W:0] pos;
    logic                    pick_last;
    logic                    out_free;

    assign full_a     = (cnt_a_reg == tsm_pkg::CNT_W'(tsm_pkg::SEQ_DEPTH));
    assign full_b     = (cnt_b_reg == tsm_pkg::CNT_W'(tsm_pkg::SEQ_DEPTH));
    assign a_avail    = (idx_a_reg < cnt_a_reg);
    assign b_avail    = (idx_b_reg < cnt_b_reg);
    assign take_a     = a_avail && (!b_avail || (head_a_reg < head_b_reg));
    assign total      = {1'b0, cnt_a_reg} + {1'b0, cnt_b_reg};
    assign pos        = {1'b0, idx_a_reg} + {1'b0, idx_b_reg} + 1'b1;
    assign both_empty = (total == '0);
    assign pick_last  = both_empty || (pos == total);
    assign out_free   = !rsp_valid_reg || !rsp_stall;

    assign sts.out_free  = out_free;
    assign sts.pick_last = pick_last;

    always_comb
    begin
        cnt_a_next     = cnt_a_reg;
        cnt_b_next     = cnt_b_reg;
        idx_a_next     = idx_a_reg;
        idx_b_next     = idx_b_reg;
        ovf_next       = ovf_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;

        if (cmd.append_a)
        begin
            if (full_a)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                cnt_a_next = cnt_a_reg + 1'b1;
            end
        end

        if (cmd.append_b)
        begin
            if (full_b)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                cnt_b_next = cnt_b_reg + 1'b1;
            end
        end

        if (cmd.start)
        begin
            idx_a_next = '0;
            idx_b_next = '0;
        end

        if (cmd.emit)
        begin
            rsp_valid_next        = 1'b1;
            rsp_next.last         = pick_last;
            rsp_next.empty_res    = both_empty;
            rsp_next.overflowed   = ovf_reg;
            if (both_empty)
            begin
                rsp_next.merged_value = '0;
                rsp_next.from_b       = 1'b0;
            end
            else if (take_a)
            begin
                rsp_next.merged_value = head_a_reg;
                rsp_next.from_b       = 1'b0;
                idx_a_next            = idx_a_reg + 1'b1;
            end
            else
            begin
                rsp_next.merged_value = head_b_reg;
                rsp_next.from_b       = 1'b1;
                idx_b_next            = idx_b_reg + 1'b1;
            end
            if (pick_last)
            begin
                cnt_a_next = '0;
                cnt_b_next = '0;
                idx_a_next = '0;
                idx_b_next = '0;
                ovf_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.append_a && !full_a)
        begin
            mem_a[cnt_a_reg[tsm_pkg::ADDR_W-1:0]] <= req_value;
        end
        if (cmd.append_b && !full_b)
        begin
            mem_b[cnt_b_reg[tsm_pkg::ADDR_W-1:0]] <= req_value;
        end
        head_a_reg <= mem_a[idx_a_next[tsm_pkg::ADDR_W-1:0]];
        head_b_reg <= mem_b[idx_b_next[tsm_pkg::ADDR_W-1:0]];
        rsp_reg    <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_a_reg     <= '0;
            cnt_b_reg     <= '0;
            idx_a_reg     <= '0;
            idx_b_reg     <= '0;
            ovf_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_a_reg     <= cnt_a_next;
            cnt_b_reg     <= cnt_b_next;
            idx_a_reg     <= idx_a_next;
            idx_b_reg     <= idx_b_next;
            ovf_reg       <= ovf_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_idx_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_a_reg <= cnt_a_reg) && (idx_b_reg <= cnt_b_reg))
        else $error("Read index passed its store's fill count.");

    a_cnt_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_a_reg <= tsm_pkg::CNT_W'(tsm_pkg::SEQ_DEPTH)) &&
        (cnt_b_reg <= tsm_pkg::CNT_W'(tsm_pkg::SEQ_DEPTH)))
        else $error("Store fill count exceeds the store depth.");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> out_free)
        else $error("Merge beat issued while the output register is held.");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && pick_last) |=> (cnt_a_reg == '0) && (cnt_b_reg == '0) && !ovf_reg)
        else $error("Stores were not emptied after the final merge beat.");

endmodule

FILE: rtl/core/two_way_sorted_merge_core.sv
// A start's results are read from the stores into the head registers and then
// registered in the output register; they come one per cycle while the output is
// not stalled, and a start with both stores empty yields a single empty result.
// The pace is one store read per merged value.
// Reset (rst_n, asynchronous, active low) empties both stores and clears overflow.
// ----------------------------------------------------------------------------
// Two-way sorted merge core
// Collects two ascending sequences and emits their merge, one value per beat.
// ----------------------------------------------------------------------------
module two_way_sorted_merge_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  tsm_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output tsm_pkg::rsp_t rsp
);

    tsm_pkg::cmd_t cmd;
    tsm_pkg::sts_t sts;

    tsm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_type  (req.req_type),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    tsm_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_value (req.value),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Two-way sorted merge core testbench
// Loads the two sequence stores with append beats and then starts a merge.
// Sequences are mostly sorted with random content, with some that are full,
// overflowing, unsorted or mixed with unused request types. A scoreboard
// predicts every merged result beat, and each accepted beat is compared with
// the prediction field by field. Both sides of the block idle at random.
// ----------------------------------------------------------------------------

class merge_scoreboard;
    int            seq_a[$];
    int            seq_b[$];
    bit            dropped;
    tsm_pkg::rsp_t expected_beats[$];
    int            n_errors;
    int            n_checked;
    int            n_merges;
    int            n_empty;
    int            n_dropped;
    int            n_ignored;

    function void predict_merge();
        tsm_pkg::rsp_t beat;
        int            ia;
        int            ib;
        int            total;
        bit            take_a;
        ia    = 0;
        ib    = 0;
        total = seq_a.size() + seq_b.size();
        n_merges++;
        if (dropped)
            n_dropped++;
        if (total == 0)
        begin
            beat            = '0;
            beat.last       = 1'b1;
            beat.empty_res  = 1'b1;
            beat.overflowed = dropped;
            expected_beats.push_back(beat);
            n_empty++;
        end
        while (ia + ib < total)
        begin
            take_a = (ia < seq_a.size()) &&
                     ((ib >= seq_b.size()) || (seq_a[ia] < seq_b[ib]));
            beat = '0;
            if (take_a)
            begin
                beat.merged_value = seq_a[ia];
                ia++;
            end
            else
            begin
                beat.merged_value = seq_b[ib];
                beat.from_b       = 1'b1;
                ib++;
            end
            beat.last       = (ia + ib == total);
            beat.overflowed = dropped;
            expected_beats.push_back(beat);
        end
        seq_a.delete();
        seq_b.delete();
        dropped = 1'b0;
    endfunction

    function void note_request(tsm_pkg::req_t item);
        case (item.req_type)
            tsm_pkg::REQ_APPEND_A:
            begin
                if (seq_a.size() < tsm_pkg::SEQ_DEPTH)
                    seq_a.push_back(item.value);
                else
                    dropped = 1'b1;
            end
            tsm_pkg::REQ_APPEND_B:
            begin
                if (seq_b.size() < tsm_pkg::SEQ_DEPTH)
                    seq_b.push_back(item.value);
                else
                    dropped = 1'b1;
            end
            tsm_pkg::REQ_START:
                predict_merge();
            default:
                n_ignored++;
        endcase
    endfunction

    function void check_result(tsm_pkg::rsp_t got);
        tsm_pkg::rsp_t want;
        if (expected_beats.size() == 0)
        begin
            $error("unexpected result beat: merged_value %0d", got.merged_value);
            n_errors++;
            return;
        end
        want = expected_beats.pop_front();
        n_checked++;
        if (got.merged_value !== want.merged_value)
        begin
            $error("merged_value: expected %0d, got %0d", want.merged_value,
                   got.merged_value);
            n_errors++;
        end
        if (got.from_b !== want.from_b)
        begin
            $error("from_b: expected %0d, got %0d", want.from_b, got.from_b);
            n_errors++;
        end
        if (got.last !== want.last)
        begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            n_errors++;
        end
        if (got.empty_res !== want.empty_res)
        begin
            $error("empty_res: expected %0d, got %0d", want.empty_res, got.empty_res);
            n_errors++;
        end
        if (got.overflowed !== want.overflowed)
        begin
            $error("overflowed: expected %0d, got %0d", want.overflowed,
                   got.overflowed);
            n_errors++;
        end
    endfunction
endclass

module tb_top;

    localparam logic [1:0] REQ_UNUSED       = 2'd3;
    localparam int         RANDOM_PER_PHASE = 87;
    localparam int         DRAIN_CYCLES     = 80;
    localparam int         CYCLE_LIMIT      = 400000;

    logic            clk;
    logic            rst_n;
    logic            req_valid;
    logic            req_stall;
    tsm_pkg::req_t   req;
    logic            rsp_valid;
    logic            rsp_stall;
    tsm_pkg::rsp_t   rsp;
    merge_scoreboard sb;
    int              send_idle_pct;
    int              recv_idle_pct;
    int              items_sent;

    two_way_sorted_merge_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(negedge clk)
        rsp_stall <= ($urandom_range(99) < recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                sb.note_request(req);
            if (rsp_valid && !rsp_stall)
                sb.check_result(rsp);
        end
    end

    function automatic int pick_value(input int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(12)) - 6;
            default:
                case ($urandom_range(3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7FFF_FFFF;
                    2: return 0;
                    default: return -1;
                endcase
        endcase
    endfunction

    task automatic send_beat(input logic [1:0] kind, input int value);
        tsm_pkg::req_t beat;
        beat          = '0;
        beat.req_type = kind;
        beat.value    = value;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= beat;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        if (kind != REQ_UNUSED)
            items_sent++;
    endtask

    task automatic run_group(input int na, input int nb, input int mode,
                             input bit scrambled);
        int va[$];
        int vb[$];
        int ia;
        int ib;
        repeat (na)
            va.push_back(pick_value(mode));
        repeat (nb)
            vb.push_back(pick_value(mode));
        if (!scrambled)
        begin
            va.sort();
            vb.sort();
        end
        ia = 0;
        ib = 0;
        while (ia < na || ib < nb)
        begin
            if ($urandom_range(19) == 0)
                send_beat(REQ_UNUSED, $urandom);
            if (ib >= nb || (ia < na && $urandom_range(1) == 1))
            begin
                send_beat(tsm_pkg::REQ_APPEND_A, va[ia]);
                ia++;
            end
            else
            begin
                send_beat(tsm_pkg::REQ_APPEND_B, vb[ib]);
                ib++;
            end
        end
        send_beat(tsm_pkg::REQ_START, $urandom);
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input int big_a,
                             input int big_b, input int stop_at);
        int roll;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        run_group(big_a, big_b, $urandom_range(2), 1'b0);
        while (items_sent < stop_at)
        begin
            roll = $urandom_range(99);
            if (roll < 6)
                run_group($urandom_range(20, 34), $urandom_range(34),
                          $urandom_range(2), $urandom_range(9) == 0);
            else
                run_group($urandom_range(6), $urandom_range(6),
                          $urandom_range(2), $urandom_range(9) == 0);
        end
    endtask

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req           = '0;
        rsp_stall     = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        items_sent    = 0;
        sb            = new;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_beat(tsm_pkg::REQ_START, 0);
        send_beat(REQ_UNUSED, -1);
        send_beat(tsm_pkg::REQ_START, 32'h7FFF_FFFF);
        send_beat(tsm_pkg::REQ_APPEND_A, 32'sh8000_0000);
        send_beat(tsm_pkg::REQ_APPEND_B, 32'sh8000_0000);
        send_beat(tsm_pkg::REQ_APPEND_A, 0);
        send_beat(tsm_pkg::REQ_APPEND_A, 32'sh7FFF_FFFF);
        send_beat(tsm_pkg::REQ_APPEND_B, 32'sh7FFF_FFFF);
        send_beat(tsm_pkg::REQ_START, -1);
        send_beat(tsm_pkg::REQ_APPEND_A, 5);
        send_beat(tsm_pkg::REQ_APPEND_A, 7);
        send_beat(tsm_pkg::REQ_START, 0);
        send_beat(tsm_pkg::REQ_APPEND_B, -1);
        send_beat(tsm_pkg::REQ_START, 0);
        send_beat(tsm_pkg::REQ_APPEND_A, 3);
        send_beat(tsm_pkg::REQ_APPEND_B, 3);
        send_beat(REQ_UNUSED, 32'h5555_AAAA);
        send_beat(tsm_pkg::REQ_APPEND_A, 3);
        send_beat(tsm_pkg::REQ_APPEND_B, 4);
        send_beat(tsm_pkg::REQ_START, 0);

        run_phase(25, 75, 34, 3, items_sent + RANDOM_PER_PHASE);
        run_phase(75, 25, 32, 32, items_sent + RANDOM_PER_PHASE);
        run_phase(0, 0, 2, 35, items_sent + RANDOM_PER_PHASE);
        @(negedge clk);
        req_valid <= 1'b0;

        while (sb.expected_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d merged beats from %0d merges: %0d with both stores empty,",
                 sb.n_checked, sb.n_merges, sb.n_empty);
        $display("%0d after a dropped append; %0d request beats, %0d unused-type beats.",
                 sb.n_dropped, items_sent, sb.n_ignored);
        if (sb.n_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
